FILE: rtl/tcw_pkg.sv
// Shared types, constants and codes of the text console character writer.
package tcw_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CUR_W       = ADDR_W + 1;
   localparam int BYTE_W      = 8;
   localparam int ROWB_W      = 8;
   localparam int ROWC_W      = 5;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int BIT_IDX_W   = $clog2(CUR_W);

   localparam logic [BYTE_W-1:0] ATTR_WHITE   = 8'd7;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [ROWB_W-1:0] ROW_BYTES_RESET = 8'd160;
   localparam logic [ROWC_W-1:0] ROW_COUNT_RESET = 5'd25;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ROW_BYTES = 1'b0,
      REG_ROW_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic {
      KIND_PUT  = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [CUR_W-1:0] a;
      logic [CUR_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [CUR_W-1:0] y;
      logic             neg;
   } alu_rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } mem_req_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GEOM_ACC,
      ST_GEOM_LAST,
      ST_RD_WAIT,
      ST_PUT_CHK,
      ST_PUT_WR0,
      ST_PUT_WR1,
      ST_BS_START,
      ST_BS_WR0,
      ST_BS_WR1,
      ST_NL_ADD,
      ST_NL_DIV,
      ST_NL_SUB,
      ST_SCROLL_CHK,
      ST_SC_COPY,
      ST_SC_ZERO,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/tcw_alu.sv
// Shared add/subtract unit; the borrow flags a negative difference.
module tcw_alu (
   input  tcw_pkg::alu_req_type req,
   output tcw_pkg::alu_rsp_type rsp
);
   import tcw_pkg::*;

   logic [CUR_W:0] sum;

   always_comb begin
      case (req.op)
         ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
         default: sum = '0;
      endcase
   end

   assign rsp.y   = sum[CUR_W-1:0];
   assign rsp.neg = sum[CUR_W];

endmodule

FILE: rtl/tcw_store.sv
// Text store: one write port and one read port with registered read data.
module tcw_store (
   input  logic                          clock,
   input  tcw_pkg::mem_req_type          req,
   output logic [tcw_pkg::BYTE_W-1:0]    rd_data
);
   import tcw_pkg::*;

   logic [BYTE_W-1:0] mem [STORE_BYTES];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule

FILE: rtl/text_console_char_writer.sv
// Top level of the text console character writer: sequencer, registers and result stage.
//
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser: kind; tdata: char_code, read_address
//  rsp_     out  rsp_tvalid/tready     tdata: read_data, cursor_after
//  csr_     in   csr_we                csr_addr, csr_wdata (row_bytes, row_count)
//
// One transaction at a time through a single add/subtract unit. A newline builds its
// remainder one dividend bit a cycle over 13 bits, and a scroll copies the window up
// one row and zero-fills the last row. After a csr write the window size is rebuilt
// one row a cycle; req_tready stays low until the rebuild is done. After reset a
// clearing pass zeroes all 4096 bytes first, then the rebuild runs. A waiting result
// in the output register does not stop the next transaction; only the hand-over at
// its end waits for the register to free up.
module text_console_char_writer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tcw_pkg::REQ_TDATA_W-1:0]    req_tdata,  // char_code[7:0], read_address[19:8]
   input  logic                               req_tuser,  // kind[0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // read_data[7:0], cursor_after[19:8]
   input  logic                               csr_we,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tcw_pkg::*;

   state_type         state_ff, state_in;
   logic [ROWB_W-1:0] row_bytes_ff;
   logic [ROWC_W-1:0] row_count_ff;
   logic              dirty_ff, dirty_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [CUR_W-1:0]  cells_ff, cells_in;
   logic [CUR_W-1:0]  last_ff, last_in;
   logic [CUR_W-1:0]  work_ff, work_in;
   logic [ROWC_W-1:0] k_ff, k_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [CUR_W-1:0]  dst_ff, dst_in;
   logic [CUR_W-1:0]  src_ff, src_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] ch_ff, ch_in;
   logic [BYTE_W-1:0] res_data_ff, res_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] rsp_cur_ff, rsp_cur_in;

   logic              accept;
   logic [BYTE_W-1:0] req_char;
   logic [ADDR_W-1:0] req_addr;
   logic [ROWB_W-1:0] w_eff;
   logic [CUR_W-1:0]  w_ext;
   logic [ROWC_W-1:0] rc_eff;
   logic [CUR_W-1:0]  dst_inc;
   logic [BYTE_W:0]   rem_shift;
   logic              geom_over;
   logic              put_fits;
   logic              copy_rd;
   logic              slot_free;
   logic [BYTE_W-1:0] mem_rd_data;
   mem_req_type       mem_req;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   tcw_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   tcw_store u_store (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (mem_rd_data)
   );

   assign req_char  = req_tdata[7:0];
   assign req_addr  = req_tdata[19:8];
   assign accept    = req_tvalid && req_tready;
   // zero row settings fall back to one cell and one row
   assign w_eff     = (row_bytes_ff == '0) ? ROWB_W'(2) : row_bytes_ff;
   assign w_ext     = CUR_W'(w_eff);
   assign rc_eff    = (row_count_ff == '0) ? ROWC_W'(1) : row_count_ff;
   assign dst_inc   = dst_ff + CUR_W'(1);
   assign rem_shift = {rem_ff, work_ff[bit_ff]};
   assign geom_over = (alu_rsp.y > CUR_W'(STORE_BYTES));
   // cursor + 1 < cells, taken from cells - cursor
   assign put_fits  = !alu_rsp.neg && (|alu_rsp.y[CUR_W-1:1]);
   assign copy_rd   = (src_ff != cells_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - ADDR_W - BYTE_W)'(0), rsp_cur_ff, rsp_data_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (dst_ff[ADDR_W-1:0] == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (dirty_ff) begin
               state_in = ST_GEOM_ACC;
            end else if (accept) begin
               if (req_tuser == KIND_READ)        state_in = ST_RD_WAIT;
               else if (req_char == CH_BACKSPACE) state_in = ST_BS_START;
               else if (req_char == CH_NEWLINE)   state_in = ST_NL_ADD;
               else                               state_in = ST_PUT_CHK;
            end
         end
         ST_GEOM_ACC: begin
            if ((k_ff == rc_eff) || geom_over) state_in = ST_GEOM_LAST;
         end
         ST_GEOM_LAST:  state_in = ST_IDLE;
         ST_RD_WAIT:    state_in = ST_FINISH;
         ST_PUT_CHK:    state_in = put_fits ? ST_PUT_WR0 : ST_SCROLL_CHK;
         ST_PUT_WR0:    state_in = ST_PUT_WR1;
         ST_PUT_WR1:    state_in = ST_SCROLL_CHK;
         ST_BS_START:   state_in = (cur_ff == '0) ? ST_FINISH : ST_BS_WR0;
         ST_BS_WR0:     state_in = ST_BS_WR1;
         ST_BS_WR1:     state_in = ST_FINISH;
         ST_NL_ADD:     state_in = ST_NL_DIV;
         ST_NL_DIV: begin
            if (bit_ff == '0) state_in = ST_NL_SUB;
         end
         ST_NL_SUB:     state_in = ST_SCROLL_CHK;
         ST_SCROLL_CHK: state_in = alu_rsp.neg ? ST_FINISH : ST_SC_COPY;
         ST_SC_COPY: begin
            if (!copy_rd && !pend_ff) state_in = ST_SC_ZERO;
         end
         ST_SC_ZERO: begin
            if (dst_inc == cells_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_CLEAR;
      endcase
   end

   // datapath, memory and unit controls
   always_comb begin
      req_tready   = 1'b0;
      dirty_in     = dirty_ff;
      cur_in       = cur_ff;
      cells_in     = cells_ff;
      last_in      = last_ff;
      work_in      = work_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      pend_in      = pend_ff;
      addr_in      = addr_ff;
      ch_in        = ch_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_cur_in   = rsp_cur_ff;
      mem_req      = '0;
      alu_req      = '{op: ALU_ADD, a: '0, b: '0};

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_ff[ADDR_W-1:0];
            mem_req.wr_data = '0;
            dst_in          = dst_inc;
         end
         ST_IDLE: begin
            req_tready      = !dirty_ff;
            work_in         = '0;
            k_in            = '0;
            mem_req.rd_en   = accept;
            mem_req.rd_addr = req_addr;
            if (accept) begin
               ch_in       = req_char;
               res_data_in = '0;
            end
         end
         ST_GEOM_ACC: begin
            alu_req = '{op: ALU_ADD, a: work_ff, b: w_ext};
            if ((k_ff == rc_eff) || geom_over) begin
               cells_in = work_ff;
            end else begin
               work_in = alu_rsp.y;
               k_in    = k_ff + ROWC_W'(1);
            end
         end
         ST_GEOM_LAST: begin
            alu_req  = '{op: ALU_SUB, a: cells_ff, b: w_ext};
            last_in  = alu_rsp.y;
            dirty_in = 1'b0;
         end
         ST_RD_WAIT: begin
            res_data_in = mem_rd_data;
         end
         ST_PUT_CHK: begin
            alu_req = '{op: ALU_SUB, a: cells_ff, b: cur_ff};
         end
         ST_PUT_WR0: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff[ADDR_W-1:0];
            mem_req.wr_data = ch_ff;
            alu_req         = '{op: ALU_ADD, a: cur_ff, b: CUR_W'(1)};
            addr_in         = alu_rsp.y[ADDR_W-1:0];
         end
         ST_PUT_WR1: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_ff;
            mem_req.wr_data = ATTR_WHITE;
            alu_req         = '{op: ALU_ADD, a: cur_ff, b: CUR_W'(2)};
            cur_in          = alu_rsp.y;
         end
         ST_BS_START: begin
            // cursor 1 steps back to 0
            alu_req = '{op: ALU_SUB, a: cur_ff, b: CUR_W'(2)};
            if (cur_ff != '0) cur_in = alu_rsp.neg ? '0 : alu_rsp.y;
         end
         ST_BS_WR0: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff[ADDR_W-1:0];
            mem_req.wr_data = CH_SPACE;
            alu_req         = '{op: ALU_ADD, a: cur_ff, b: CUR_W'(1)};
            addr_in         = alu_rsp.y[ADDR_W-1:0];
         end
         ST_BS_WR1: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = addr_ff;
            mem_req.wr_data = ATTR_WHITE;
         end
         ST_NL_ADD: begin
            alu_req = '{op: ALU_ADD, a: cur_ff, b: w_ext};
            work_in = alu_rsp.y;
            rem_in  = '0;
            bit_in  = BIT_IDX_W'(CUR_W - 1);
         end
         ST_NL_DIV: begin
            // restoring remainder, one dividend bit a cycle
            alu_req = '{op: ALU_SUB, a: CUR_W'(rem_shift), b: w_ext};
            rem_in  = alu_rsp.neg ? rem_shift[BYTE_W-1:0] : alu_rsp.y[BYTE_W-1:0];
            bit_in  = bit_ff - BIT_IDX_W'(1);
         end
         ST_NL_SUB: begin
            alu_req = '{op: ALU_SUB, a: work_ff, b: CUR_W'(rem_ff)};
            cur_in  = alu_rsp.y;
         end
         ST_SCROLL_CHK: begin
            alu_req = '{op: ALU_SUB, a: cur_ff, b: cells_ff};
            dst_in  = '0;
            src_in  = w_ext;
            pend_in = 1'b0;
         end
         ST_SC_COPY: begin
            // read one row ahead, write the byte fetched last cycle
            mem_req.rd_en   = copy_rd;
            mem_req.rd_addr = src_ff[ADDR_W-1:0];
            mem_req.wr_en   = pend_ff;
            mem_req.wr_addr = dst_ff[ADDR_W-1:0];
            mem_req.wr_data = mem_rd_data;
            if (copy_rd) src_in = src_ff + CUR_W'(1);
            if (pend_ff) dst_in = dst_inc;
            pend_in = copy_rd;
         end
         ST_SC_ZERO: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = dst_ff[ADDR_W-1:0];
            mem_req.wr_data = '0;
            dst_in          = dst_inc;
            cur_in          = last_ff;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_cur_in   = cur_ff[ADDR_W-1:0];
            end
         end
         default: begin
         end
      endcase

      if (csr_we) dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_bytes_ff <= ROW_BYTES_RESET;
         row_count_ff <= ROW_COUNT_RESET;
         dirty_ff     <= 1'b1;
         cur_ff       <= '0;
         dst_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         cur_ff       <= cur_in;
         dst_ff       <= dst_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_ROW_BYTES: row_bytes_ff <= csr_wdata[ROWB_W-1:0];
               REG_ROW_COUNT: row_count_ff <= csr_wdata[ROWC_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cells_ff    <= cells_in;
      last_ff     <= last_in;
      work_ff     <= work_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      src_ff      <= src_in;
      addr_ff     <= addr_in;
      ch_ff       <= ch_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

endmodule

FILE: rtl/tcw_checker.sv
// Port-level assertions for the text console character writer, bound to the top level.
module tcw_port_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            csr_we
);
   import tcw_pkg::*;

   // clearing pass keeps the input closed right after reset
   a_closed_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("req_tready high straight after reset");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction taken while busy");

   // a csr write forces a geometry rebuild before the next transaction
   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_tready)
      else $error("req_tready high right after a csr write");

   // no result can appear the cycle after an input is taken
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result raised one cycle after acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind text_console_char_writer tcw_port_checker u_tcw_checker (.*);

FILE: dv/tcw_checker.sv
// Checker for the text console writer: tracks the buffer and cursor, compares every result.
module tcw_checker
   import tcw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [11:0] cursor_after;
      logic [7:0]  read_data;
   } console_rsp_type;

   logic [BYTE_W-1:0] screen_copy [STORE_BYTES];
   int unsigned       cursor;
   logic [ROWB_W-1:0] row_bytes;
   logic [ROWC_W-1:0] row_count;
   console_rsp_type   pending_rsp [$];

   function automatic void poke(int unsigned addr, logic [7:0] value);
      if (addr < STORE_BYTES)
         screen_copy[addr] = value;
   endfunction

   // Applies one transaction to the shadow buffer and returns what the block should answer.
   function automatic console_rsp_type console_step(kind_type kind, logic [7:0] ch,
                                                    logic [11:0] addr);
      console_rsp_type res;
      int unsigned     w;
      int unsigned     r;
      int unsigned     cells;
      int unsigned     last;
      res.read_data = '0;
      if (kind == KIND_READ) begin
         res.read_data = screen_copy[addr];
      end else begin
         w = (row_bytes != 0) ? row_bytes : 2;
         if (w > STORE_BYTES) w = STORE_BYTES;
         r = (row_count != 0) ? row_count : 1;
         if (r > STORE_BYTES / w) r = STORE_BYTES / w;
         cells = w * r;
         if (ch == CH_BACKSPACE) begin
            if (cursor > 0) begin
               cursor = (cursor >= 2) ? cursor - 2 : 0;
               poke(cursor, CH_SPACE);
               poke(cursor + 1, ATTR_WHITE);
            end
         end else begin
            if (ch == CH_NEWLINE) begin
               cursor = cursor + w;
               cursor = cursor - cursor % w;
            end else if (cursor + 1 < cells) begin
               poke(cursor, ch);
               poke(cursor + 1, ATTR_WHITE);
               cursor = cursor + 2;
            end
            // scroll up one row; bytes past the window stay put
            if (cursor >= cells) begin
               last = (r - 1) * w;
               for (int unsigned i = 0; i < last; i++)
                  screen_copy[i] = screen_copy[i + w];
               for (int unsigned i = 0; i < w; i++)
                  poke(last + i, '0);
               cursor = last;
            end
         end
      end
      res.cursor_after = cursor[11:0];
      return res;
   endfunction

   always @(posedge clock) begin
      console_rsp_type want;
      console_rsp_type got;
      if (reset) begin
         foreach (screen_copy[i]) screen_copy[i] = '0;
         cursor     = 0;
         row_bytes  = ROW_BYTES_RESET;
         row_count  = ROW_COUNT_RESET;
         fail_count = 0;
         pending_rsp.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == REG_ROW_BYTES)
               row_bytes = csr_wdata[ROWB_W-1:0];
            else if (csr_addr == REG_ROW_COUNT)
               row_count = csr_wdata[ROWC_W-1:0];
         end
         if (req_tvalid && req_tready)
            pending_rsp.push_back(console_step(kind_type'(req_tuser), req_tdata[7:0],
                                               req_tdata[19:8]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[19:0];
            if (pending_rsp.size() == 0) begin
               $error("unexpected result transaction: read_data %0d, cursor_after %0d",
                      got.read_data, got.cursor_after);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.read_data !== want.read_data) begin
                  $error("read_data: expected %0d, actual %0d", want.read_data,
                         got.read_data);
                  fail_count++;
               end
               if (got.cursor_after !== want.cursor_after) begin
                  $error("cursor_after: expected %0d, actual %0d", want.cursor_after,
                         got.cursor_after);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: dv/tb.sv
// Testbench top for the text console writer: stimulus, geometry changes and verdict.
module tb;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // char_code[7:0], read_address[19:8]
   logic                   req_tuser  = 1'b0; // kind[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // read_data[7:0], cursor_after[19:8]
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int fail_count;
   int sent        = 0;
   int got         = 0;
   int geometries  = 1;
   bit calm        = 1'b0;
   bit held        = 1'b0;
   int unsigned peek_span = 4000;

   text_console_char_writer dut (.*);

   tcw_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always_ff @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) got <= got + 1;
   end

   // Result side: random back-pressure, plus one long hold-off to fill the block up.
   initial begin
      forever begin
         @(posedge clock);
         if (!held && got >= 700) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   task automatic send_item(kind_type kind, logic [7:0] ch, logic [11:0] addr);
      if (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, addr, ch};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic put(logic [7:0] ch);
      send_item(KIND_PUT, ch, 12'($urandom));
   endtask

   task automatic peek(logic [11:0] addr);
      send_item(KIND_READ, 8'($urandom), addr);
   endtask

   // Drain everything, let the block settle, then rewrite both geometry registers.
   task automatic set_geometry(int unsigned rb, int unsigned rc);
      req_tvalid <= 1'b0;
      while (got != sent) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_ROW_BYTES;
      csr_wdata <= CSR_DATA_W'(rb);
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (32) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_ROW_COUNT;
      csr_wdata <= CSR_DATA_W'(rc);
      @(posedge clock);
      csr_we <= 1'b0;
      repeat (32) @(posedge clock);
      peek_span = rb * rc;
      geometries++;
   endtask

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50)
         put(8'($urandom));
      else if (pick < 60)
         put(CH_NEWLINE);
      else if (pick < 70)
         put(CH_BACKSPACE);
      else if ($urandom_range(1))
         peek(12'($urandom_range(peek_span - 1)));
      else
         peek(12'($urandom));
   endtask

   initial begin
      int unsigned rb_list [10] = '{160, 2, 7, 16, 160, 2, 33, 40, 0, 0};
      int unsigned rc_list [10] = '{25, 1, 3, 4, 1, 25, 5, 10, 0, 0};
      int unsigned rb;
      int unsigned rc;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default geometry: backspace at origin, byte extremes, newline, reads
      put(CH_BACKSPACE);
      put(8'h00);
      put(8'hFF);
      put("A");
      put(CH_NEWLINE);
      peek(12'd0);
      peek(12'd1);
      peek(12'd4095);
      peek(12'd3);
      put(CH_BACKSPACE);

      // odd width, cursor left outside the shrunk window
      set_geometry(3, 2);
      put("x");
      put(CH_BACKSPACE);  // lands on cursor 1
      put(CH_BACKSPACE);  // from 1 down to 0
      put(CH_BACKSPACE);
      put("y");
      put("z");
      put("w");           // fills the window, scrolls
      put(CH_NEWLINE);
      peek(12'd0);
      peek(12'd3);
      peek(12'd5);
      peek(12'd158);

      // narrowest window: put at the window end
      set_geometry(2, 1);
      put("q");
      put("r");
      peek(12'd0);

      for (int p = 0; p < 10; p++) begin
         rb = rb_list[p];
         rc = rc_list[p];
         if (rb == 0) begin
            rb = $urandom_range(2, 160);
            rc = $urandom_range(1, 25);
         end
         set_geometry(rb, rc);
         calm = (p == 3);
         repeat (155) random_item();
         calm = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (got != sent) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("tb: %0d transactions checked over %0d window geometries", sent, geometries);
      $display("tb: puts, newlines, backspaces, reads, scrolls and a long result stall");
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #300ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
